/* hdl/wfts_pkg.sv */
// ----------------------------------------------------------------------------
// wfts_pkg - shared types and constants of the weighted fair task scheduler
// Command codes, slot states, status codes, queue word and divider bundles.
// ----------------------------------------------------------------------------
package wfts_pkg;

   localparam int TASK_SLOTS_DEF = 16;
   localparam int QUEUE_DEPTH    = 2;
   localparam int DIV_W          = 22;     // covers 2^20 + weight and slice terms

   localparam logic [3:0]  SLICE_RESET = 4'd8;
   localparam logic [12:0] WEIGHT_MAX  = 13'd4096;
   localparam logic [12:0] BOOT_WEIGHT = 13'd1024;
   localparam logic [31:0] BOOT_IDENT  = 32'd1;
   localparam logic [31:0] FIRST_IDENT = 32'd3;
   localparam logic [DIV_W-1:0] CHARGE_NUM = DIV_W'(1024 * 1024);

   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_YIELD  = 3'd1;
   localparam logic [2:0] MODE_CREATE = 3'd2;
   localparam logic [2:0] MODE_SLEEP  = 3'd3;
   localparam logic [2:0] MODE_EXIT   = 3'd4;
   localparam logic [2:0] MODE_REAP   = 3'd5;

   typedef enum logic [2:0] {
      OP_TICK, OP_YIELD, OP_CREATE, OP_SLEEP, OP_EXIT, OP_REAP, OP_BAD
   } op_type;

   typedef enum logic [2:0] {
      SL_UNUSED   = 3'd0,
      SL_READY    = 3'd1,
      SL_RUNNING  = 3'd2,
      SL_SLEEPING = 3'd3,
      SL_ZOMBIE   = 3'd4
   } slot_state_type;

   typedef enum logic [2:0] {
      RS_OK       = 3'd0,
      RS_INVALID  = 3'd1,
      RS_NOSPACE  = 3'd2,
      RS_NOTFOUND = 3'd3,
      RS_BUSY     = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      FS_INIT, FS_IDLE, FS_DISPATCH, FS_EX_CHK,
      FS_CR_RD, FS_CR_EV, FS_CR_DO,
      FS_RP_RD, FS_RP_EV,
      FS_SCHED, FS_CH_DIV, FS_CH_WAIT, FS_DEC,
      FS_MN_RD, FS_MN_EV,
      FS_WK_RD, FS_WK_EV, FS_WK_WR,
      FS_CHK, FS_PK_RD, FS_PK_EV, FS_PK_END, FS_SL_WAIT,
      FS_RESP
   } fsm_type;

   typedef struct packed {
      op_type      op;
      logic        bad_weight;
      logic        sleep_zero;
      logic [63:0] now;
      logic [12:0] weight;
      logic [63:0] sleep_ticks;
      logic [31:0] exit_value;
      logic [31:0] task_id;
   } cmd_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quo;
   } div_rsp_type;

endpackage

/* hdl/weighted_fair_task_scheduler.sv */
// ----------------------------------------------------------------------------
// weighted_fair_task_scheduler - one-CPU weighted fair scheduler
// Command intake, queue, table sequencer and shared divider.
// ----------------------------------------------------------------------------
// Use:
//  - A command word (tick, yield, create, sleep, exit, reap) is taken at a
//    clock edge with start high and busy low. Two words may wait in the
//    intake queue; busy rises when it is full.
//  - Every word gives exactly one result word, shown for one cycle with
//    rsp_valid high. The receiver cannot stall; it must take it then.
//  - csr_we writes slice_limit (reset 8); write it only while idle.
// Work per word:
//  - invalid commands and an idle tick with nothing pending: no table scan
//  - create and reap: at most one scan of the table
//  - a schedule: up to three passes over the single read port of the table
//    memories and up to two runs of the bit-serial divider, plus a write
//    step per woken sleeper.
// Reset: the boot task is written into slot 0 in the first cycle after
// reset; words arriving meanwhile wait in the queue.
// ----------------------------------------------------------------------------
module weighted_fair_task_scheduler
   import wfts_pkg::*;
#(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [63:0] req_now,
   input  logic [12:0] req_weight,
   input  logic [63:0] req_sleep_ticks,
   input  logic [31:0] req_exit_value,
   input  logic [31:0] req_task_id,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_running_slot,
   output logic        rsp_running_idle,
   output logic        rsp_switched,
   output logic [3:0]  rsp_slice_left,
   output logic [31:0] rsp_new_id,
   output logic [31:0] rsp_reap_code,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);

   logic [3:0]  slice_limit_ff;
   logic        q_valid;
   logic        q_pop;
   cmd_type     q_word;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // slice limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         slice_limit_ff <= SLICE_RESET;
      end else if (csr_we) begin
         slice_limit_ff <= csr_wdata;
      end
   end

   // intake: decode, check and queue each word
   wfts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_now         (req_now),
      .req_weight      (req_weight),
      .req_sleep_ticks (req_sleep_ticks),
      .req_exit_value  (req_exit_value),
      .req_task_id     (req_task_id),
      .q_valid         (q_valid),
      .q_word          (q_word),
      .q_pop           (q_pop)
   );

   // charge and slice quotients
   wfts_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // table sequencer
   wfts_back #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .slice_limit      (slice_limit_ff),
      .q_valid          (q_valid),
      .q_word           (q_word),
      .q_pop            (q_pop),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_running_slot (rsp_running_slot),
      .rsp_running_idle (rsp_running_idle),
      .rsp_switched     (rsp_switched),
      .rsp_slice_left   (rsp_slice_left),
      .rsp_new_id       (rsp_new_id),
      .rsp_reap_code    (rsp_reap_code)
   );

endmodule

/* hdl/wfts_div.sv */
// ----------------------------------------------------------------------------
// wfts_div - restoring divider
// One quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module wfts_div
   import wfts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
      if (req.start) begin
         rem_in = '0;
         quo_in = req.num;
         den_in = req.den;
         cnt_in = CNT_W'(DIV_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

/* hdl/wfts_front.sv */
// ----------------------------------------------------------------------------
// wfts_front - command intake
// Decodes and checks each command word and holds it in a short queue.
// ----------------------------------------------------------------------------
module wfts_front
   import wfts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [63:0] req_now,
   input  logic [12:0] req_weight,
   input  logic [63:0] req_sleep_ticks,
   input  logic [31:0] req_exit_value,
   input  logic [31:0] req_task_id,
   output logic        q_valid,
   output cmd_type     q_word,
   input  logic        q_pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   cmd_type          word;
   logic             accept;

   always_comb begin
      word = '0;
      case (req_mode)
         MODE_TICK:   word.op = OP_TICK;
         MODE_YIELD:  word.op = OP_YIELD;
         MODE_CREATE: word.op = OP_CREATE;
         MODE_SLEEP:  word.op = OP_SLEEP;
         MODE_EXIT:   word.op = OP_EXIT;
         MODE_REAP:   word.op = OP_REAP;
         default:     word.op = OP_BAD;
      endcase
      word.bad_weight  = (req_weight == '0) || (req_weight > WEIGHT_MAX);
      word.sleep_zero  = (req_sleep_ticks == '0);
      word.now         = req_now;
      word.weight      = req_weight;
      word.sleep_ticks = req_sleep_ticks;
      word.exit_value  = req_exit_value;
      word.task_id     = req_task_id;
   end

   assign busy    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign accept  = start && !busy;
   assign q_valid = (count_ff != '0);
   assign q_word  = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(accept) - CNT_W'(q_pop);
      end
      if (accept) begin
         queue_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

/* hdl/wfts_back.sv */
// ----------------------------------------------------------------------------
// wfts_back - command execution
// Sequencer over the task table: charge, wake, pick, slice, create, sleep, exit, reap.
// ----------------------------------------------------------------------------
module wfts_back
   import wfts_pkg::*;
#(
   parameter int TASK_SLOTS = TASK_SLOTS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [3:0]  slice_limit,
   input  logic        q_valid,
   input  cmd_type     q_word,
   output logic        q_pop,
   output div_req_type div_req,
   input  div_rsp_type div_rsp,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_running_slot,
   output logic        rsp_running_idle,
   output logic        rsp_switched,
   output logic [3:0]  rsp_slice_left,
   output logic [31:0] rsp_new_id,
   output logic [31:0] rsp_reap_code
);

   localparam int IDX_W = $clog2(TASK_SLOTS);
   localparam int SUM_W = $clog2(TASK_SLOTS * 4096 + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_SLOTS - 1);

   // table memories
   logic [12:0] weight_mem [TASK_SLOTS];
   logic [63:0] vrt_mem    [TASK_SLOTS];
   logic [63:0] wake_mem   [TASK_SLOTS];
   logic [31:0] ident_mem  [TASK_SLOTS];
   logic [31:0] exit_mem   [TASK_SLOTS];
   logic [12:0] weight_q;
   logic [63:0] vrt_q, wake_q;
   logic [31:0] ident_q, exit_q;

   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             wr_weight, wr_vrt, wr_wake, wr_ident, wr_exit;
   logic [12:0]      wr_weight_d;
   logic [63:0]      wr_vrt_d, wr_wake_d;
   logic [31:0]      wr_ident_d, wr_exit_d;

   slot_state_type   slot_st_ff [TASK_SLOTS];
   slot_state_type   slot_st_in [TASK_SLOTS];

   fsm_type          state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic             forced_ff, forced_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic             idle_ff, idle_in;
   logic [3:0]       slice_ff, slice_in;
   logic [63:0]      floor_ff, floor_in;
   logic             wp_ff, wp_in;
   logic [31:0]      next_id_ff, next_id_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             any_ff, any_in;
   logic [63:0]      min_ff, min_in;
   logic             free_ok_ff, free_ok_in;
   logic [IDX_W-1:0] free_ff, free_in;
   logic             sleepers_ff, sleepers_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] best_ff, best_in;
   logic [63:0]      bvrt_ff, bvrt_in;
   logic [31:0]      bid_ff, bid_in;
   logic [12:0]      bw_ff, bw_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [63:0]      vtmp_ff, vtmp_in;
   status_type       status_ff, status_in;
   logic             sw_ff, sw_in;
   logic [31:0]      new_id_ff, new_id_in;
   logic [31:0]      code_ff, code_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [3:0]       rsp_slot_ff, rsp_slot_in;
   logic             rsp_idle_ff, rsp_idle_in;
   logic             rsp_sw_ff, rsp_sw_in;
   logic [3:0]       rsp_slice_ff, rsp_slice_in;
   logic [31:0]      rsp_new_id_ff, rsp_new_id_in;
   logic [31:0]      rsp_code_ff, rsp_code_in;

   logic [63:0]      floor_pick;   // floor after a floor update
   logic [63:0]      wake_vrt;
   logic [12:0]      charge_w;
   logic             run_old;
   logic [3:0]       slice_clip;
   logic [16:0]      lim_w;

   always_ff @(posedge clock) begin
      if (wr_weight) weight_mem[wr_addr] <= wr_weight_d;
      if (wr_vrt)    vrt_mem[wr_addr]    <= wr_vrt_d;
      if (wr_wake)   wake_mem[wr_addr]   <= wr_wake_d;
      if (wr_ident)  ident_mem[wr_addr]  <= wr_ident_d;
      if (wr_exit)   exit_mem[wr_addr]   <= wr_exit_d;
      weight_q <= weight_mem[rd_addr];
      vrt_q    <= vrt_mem[rd_addr];
      wake_q   <= wake_mem[rd_addr];
      ident_q  <= ident_mem[rd_addr];
      exit_q   <= exit_mem[rd_addr];
   end

   assign floor_pick = (any_ff && (min_ff > floor_ff)) ? min_ff : floor_ff;
   assign wake_vrt   = (vtmp_ff > floor_ff) ? vtmp_ff : floor_ff;
   assign charge_w   = (weight_q == '0) ? 13'd1 : weight_q;
   assign run_old    = !idle_ff && (slot_st_ff[cur_ff] == SL_RUNNING);
   assign lim_w      = 17'(slice_limit) * 17'(bw_ff);
   assign slice_clip = (div_rsp.quo > DIV_W'(slice_limit)) ? slice_limit
                                                           : div_rsp.quo[3:0];

   always_comb begin
      state_in      = state_ff;
      slot_st_in    = slot_st_ff;
      cmd_in        = cmd_ff;
      forced_in     = forced_ff;
      cur_in        = cur_ff;
      idle_in       = idle_ff;
      slice_in      = slice_ff;
      floor_in      = floor_ff;
      wp_in         = wp_ff;
      next_id_in    = next_id_ff;
      idx_in        = idx_ff;
      any_in        = any_ff;
      min_in        = min_ff;
      free_ok_in    = free_ok_ff;
      free_in       = free_ff;
      sleepers_in   = sleepers_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      bvrt_in       = bvrt_ff;
      bid_in        = bid_ff;
      bw_in         = bw_ff;
      sum_in        = sum_ff;
      vtmp_in       = vtmp_ff;
      status_in     = status_ff;
      sw_in         = sw_ff;
      new_id_in     = new_id_ff;
      code_in       = code_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_idle_in   = rsp_idle_ff;
      rsp_sw_in     = rsp_sw_ff;
      rsp_slice_in  = rsp_slice_ff;
      rsp_new_id_in = rsp_new_id_ff;
      rsp_code_in   = rsp_code_ff;
      q_pop         = 1'b0;
      rd_addr       = idx_ff;
      wr_addr       = idx_ff;
      wr_weight     = 1'b0;
      wr_vrt        = 1'b0;
      wr_wake       = 1'b0;
      wr_ident      = 1'b0;
      wr_exit       = 1'b0;
      wr_weight_d   = '0;
      wr_vrt_d      = '0;
      wr_wake_d     = '0;
      wr_ident_d    = '0;
      wr_exit_d     = '0;
      div_req       = '0;

      case (state_ff)
         FS_INIT: begin
            // boot task in slot 0
            wr_addr     = '0;
            wr_weight   = 1'b1;
            wr_vrt      = 1'b1;
            wr_wake     = 1'b1;
            wr_ident    = 1'b1;
            wr_exit     = 1'b1;
            wr_weight_d = BOOT_WEIGHT;
            wr_ident_d  = BOOT_IDENT;
            state_in    = FS_IDLE;
         end
         FS_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               cmd_in    = q_word;
               status_in = RS_OK;
               sw_in     = 1'b0;
               new_id_in = '0;
               code_in   = '0;
               state_in  = FS_DISPATCH;
            end
         end
         FS_DISPATCH: begin
            case (cmd_ff.op)
               OP_TICK: begin
                  forced_in = 1'b0;
                  state_in  = FS_SCHED;
               end
               OP_YIELD: begin
                  forced_in = 1'b1;
                  state_in  = FS_SCHED;
               end
               OP_CREATE: begin
                  if (cmd_ff.bad_weight) begin
                     status_in = RS_INVALID;
                     state_in  = FS_RESP;
                  end else if (next_id_ff == '0) begin
                     status_in = RS_NOSPACE;
                     state_in  = FS_RESP;
                  end else begin
                     idx_in     = '0;
                     any_in     = 1'b0;
                     free_ok_in = 1'b0;
                     state_in   = FS_CR_RD;
                  end
               end
               OP_SLEEP: begin
                  if (cmd_ff.sleep_zero) begin
                     forced_in = 1'b1;
                     state_in  = FS_SCHED;
                  end else if (idle_ff) begin
                     status_in = RS_INVALID;
                     state_in  = FS_RESP;
                  end else begin
                     wr_addr            = cur_ff;
                     wr_wake            = 1'b1;
                     wr_wake_d          = cmd_ff.now + cmd_ff.sleep_ticks;
                     slot_st_in[cur_ff] = SL_SLEEPING;
                     forced_in          = 1'b1;
                     state_in           = FS_SCHED;
                  end
               end
               OP_EXIT: begin
                  if (idle_ff) begin
                     status_in = RS_INVALID;
                     state_in  = FS_RESP;
                  end else begin
                     rd_addr  = cur_ff;
                     state_in = FS_EX_CHK;
                  end
               end
               OP_REAP: begin
                  idx_in   = '0;
                  state_in = FS_RP_RD;
               end
               default: begin
                  status_in = RS_INVALID;
                  state_in  = FS_RESP;
               end
            endcase
         end
         FS_EX_CHK: begin
            if (ident_q == BOOT_IDENT) begin
               status_in = RS_INVALID;
               state_in  = FS_RESP;
            end else begin
               wr_addr            = cur_ff;
               wr_exit            = 1'b1;
               wr_exit_d          = cmd_ff.exit_value;
               slot_st_in[cur_ff] = SL_ZOMBIE;
               forced_in          = 1'b1;
               state_in           = FS_SCHED;
            end
         end
         FS_CR_RD: begin
            state_in = FS_CR_EV;
         end
         FS_CR_EV: begin
            if ((slot_st_ff[idx_ff] inside {SL_READY, SL_RUNNING}) &&
                (!any_ff || vrt_q < min_ff)) begin
               min_in = vrt_q;
               any_in = 1'b1;
            end
            if (slot_st_ff[idx_ff] == SL_UNUSED && !free_ok_ff) begin
               free_in    = idx_ff;
               free_ok_in = 1'b1;
            end
            if (idx_ff == IDX_LAST) begin
               state_in = FS_CR_DO;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = FS_CR_RD;
            end
         end
         FS_CR_DO: begin
            if (!free_ok_ff) begin
               status_in = RS_NOSPACE;
            end else begin
               floor_in            = floor_pick;
               wr_addr             = free_ff;
               wr_weight           = 1'b1;
               wr_vrt              = 1'b1;
               wr_wake             = 1'b1;
               wr_ident            = 1'b1;
               wr_exit             = 1'b1;
               wr_weight_d         = cmd_ff.weight;
               wr_vrt_d            = floor_pick;
               wr_ident_d          = next_id_ff;
               slot_st_in[free_ff] = SL_READY;
               wp_in               = 1'b1;
               new_id_in           = next_id_ff;
               next_id_in          = next_id_ff + 1'b1;
            end
            state_in = FS_RESP;
         end
         FS_RP_RD: begin
            state_in = FS_RP_EV;
         end
         FS_RP_EV: begin
            if (slot_st_ff[idx_ff] != SL_UNUSED && ident_q == cmd_ff.task_id) begin
               if (slot_st_ff[idx_ff] != SL_ZOMBIE || (!idle_ff && cur_ff == idx_ff)) begin
                  status_in = RS_BUSY;
               end else begin
                  code_in            = exit_q;
                  slot_st_in[idx_ff] = SL_UNUSED;
               end
               state_in = FS_RESP;
            end else if (idx_ff == IDX_LAST) begin
               status_in = RS_NOTFOUND;
               state_in  = FS_RESP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = FS_RP_RD;
            end
         end
         FS_SCHED: begin
            if (!forced_ff && idle_ff && !wp_ff) begin
               state_in = FS_RESP;
            end else if (run_old) begin
               rd_addr  = cur_ff;
               state_in = FS_CH_DIV;
            end else begin
               state_in = FS_DEC;
            end
         end
         FS_CH_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = CHARGE_NUM + DIV_W'(charge_w) - 1'b1;
            div_req.den   = DIV_W'(charge_w);
            vtmp_in       = vrt_q;
            state_in      = FS_CH_WAIT;
         end
         FS_CH_WAIT: begin
            if (div_rsp.done) begin
               wr_addr  = cur_ff;
               wr_vrt   = 1'b1;
               wr_vrt_d = vtmp_ff + 64'(div_rsp.quo);
               state_in = FS_DEC;
            end
         end
         FS_DEC: begin
            if (!forced_ff && slice_ff != '0) begin
               slice_in = slice_ff - 1'b1;
            end
            idx_in   = '0;
            any_in   = 1'b0;
            state_in = FS_MN_RD;
         end
         FS_MN_RD: begin
            state_in = FS_MN_EV;
         end
         FS_MN_EV: begin
            if ((slot_st_ff[idx_ff] inside {SL_READY, SL_RUNNING}) &&
                (!any_ff || vrt_q < min_ff)) begin
               min_in = vrt_q;
               any_in = 1'b1;
            end
            if (idx_ff == IDX_LAST) begin
               idx_in      = '0;
               sleepers_in = 1'b0;
               state_in    = FS_WK_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = FS_MN_RD;
            end
         end
         FS_WK_RD: begin
            state_in = FS_WK_EV;
         end
         FS_WK_EV: begin
            if (slot_st_ff[idx_ff] == SL_SLEEPING && cmd_ff.now >= wake_q) begin
               floor_in = floor_pick;
               vtmp_in  = vrt_q;
               state_in = FS_WK_WR;
            end else begin
               if (slot_st_ff[idx_ff] == SL_SLEEPING) begin
                  sleepers_in = 1'b1;
               end
               if (idx_ff == IDX_LAST) begin
                  state_in = FS_CHK;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = FS_WK_RD;
               end
            end
         end
         FS_WK_WR: begin
            // woken vruntime is at least the floor, so the running minimum
            // only changes when the set was empty
            wr_vrt             = 1'b1;
            wr_vrt_d           = wake_vrt;
            slot_st_in[idx_ff] = SL_READY;
            wp_in              = 1'b1;
            if (!any_ff) begin
               min_in = wake_vrt;
            end
            any_in = 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = FS_CHK;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = FS_WK_RD;
            end
         end
         FS_CHK: begin
            if (run_old && !forced_ff && slice_ff != '0) begin
               state_in = FS_RESP;
            end else begin
               if (run_old) begin
                  slot_st_in[cur_ff] = SL_READY;
               end
               idx_in   = '0;
               found_in = 1'b0;
               sum_in   = '0;
               state_in = FS_PK_RD;
            end
         end
         FS_PK_RD: begin
            state_in = FS_PK_EV;
         end
         FS_PK_EV: begin
            if (slot_st_ff[idx_ff] == SL_READY) begin
               sum_in = sum_ff + SUM_W'(weight_q);
               if (!found_ff || vrt_q < bvrt_ff ||
                   (vrt_q == bvrt_ff && ident_q < bid_ff)) begin
                  best_in  = idx_ff;
                  bvrt_in  = vrt_q;
                  bid_in   = ident_q;
                  bw_in    = weight_q;
                  found_in = 1'b1;
               end
            end
            if (idx_ff == IDX_LAST) begin
               state_in = FS_PK_END;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = FS_PK_RD;
            end
         end
         FS_PK_END: begin
            wp_in   = found_ff || sleepers_ff;
            sw_in   = (found_ff == idle_ff) || (found_ff && best_ff != cur_ff);
            cur_in  = found_ff ? best_ff : '0;
            idle_in = !found_ff;
            if (found_ff) begin
               slot_st_in[best_ff] = SL_RUNNING;
               if (bvrt_ff > floor_ff) begin
                  floor_in = bvrt_ff;
               end
            end
            if (found_ff && sum_ff != '0) begin
               div_req.start = 1'b1;
               div_req.num   = DIV_W'(lim_w) + DIV_W'(sum_ff) - 1'b1;
               div_req.den   = DIV_W'(sum_ff);
               state_in      = FS_SL_WAIT;
            end else begin
               slice_in = 4'd1;
               state_in = FS_RESP;
            end
         end
         FS_SL_WAIT: begin
            if (div_rsp.done) begin
               slice_in = (slice_clip == '0) ? 4'd1 : slice_clip;
               state_in = FS_RESP;
            end
         end
         FS_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_slot_in   = idle_ff ? 4'd0 : 4'(cur_ff);
            rsp_idle_in   = idle_ff;
            rsp_sw_in     = sw_ff;
            rsp_slice_in  = slice_ff;
            rsp_new_id_in = new_id_ff;
            rsp_code_in   = code_ff;
            state_in      = FS_IDLE;
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FS_INIT;
         for (int i = 0; i < TASK_SLOTS; i++) begin
            slot_st_ff[i] <= (i == 0) ? SL_RUNNING : SL_UNUSED;
         end
         cur_ff       <= '0;
         idle_ff      <= 1'b0;
         slice_ff     <= '0;
         floor_ff     <= '0;
         wp_ff        <= 1'b0;
         next_id_ff   <= FIRST_IDENT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_st_ff   <= slot_st_in;
         cur_ff       <= cur_in;
         idle_ff      <= idle_in;
         slice_ff     <= slice_in;
         floor_ff     <= floor_in;
         wp_ff        <= wp_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      forced_ff     <= forced_in;
      idx_ff        <= idx_in;
      any_ff        <= any_in;
      min_ff        <= min_in;
      free_ok_ff    <= free_ok_in;
      free_ff       <= free_in;
      sleepers_ff   <= sleepers_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      bvrt_ff       <= bvrt_in;
      bid_ff        <= bid_in;
      bw_ff         <= bw_in;
      sum_ff        <= sum_in;
      vtmp_ff       <= vtmp_in;
      status_ff     <= status_in;
      sw_ff         <= sw_in;
      new_id_ff     <= new_id_in;
      code_ff       <= code_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_idle_ff   <= rsp_idle_in;
      rsp_sw_ff     <= rsp_sw_in;
      rsp_slice_ff  <= rsp_slice_in;
      rsp_new_id_ff <= rsp_new_id_in;
      rsp_code_ff   <= rsp_code_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_running_slot = rsp_slot_ff;
   assign rsp_running_idle = rsp_idle_ff;
   assign rsp_switched     = rsp_sw_ff;
   assign rsp_slice_left   = rsp_slice_ff;
   assign rsp_new_id       = rsp_new_id_ff;
   assign rsp_reap_code    = rsp_code_ff;

endmodule

/* hdl/wfts_checker.sv */
// ----------------------------------------------------------------------------
// wfts_checker - port-level checks of the scheduler
// Result strobe spacing, consistency of result fields and quiet after reset.
// ----------------------------------------------------------------------------
module wfts_checker
   import wfts_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [3:0]  rsp_running_slot,
   input logic        rsp_running_idle,
   input logic        rsp_switched,
   input logic [31:0] rsp_new_id,
   input logic [31:0] rsp_reap_code
);

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe on two cycles running");

   a_idle_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_running_idle |-> rsp_running_slot == 4'd0)
      else $error("idle task shown with a slot");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != RS_OK |->
         !rsp_switched && rsp_new_id == '0 && rsp_reap_code == '0)
      else $error("failed word carries results");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result straight after reset");

endmodule

bind weighted_fair_task_scheduler wfts_checker u_wfts_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_running_slot (rsp_running_slot),
   .rsp_running_idle (rsp_running_idle),
   .rsp_switched     (rsp_switched),
   .rsp_new_id       (rsp_new_id),
   .rsp_reap_code    (rsp_reap_code)
);
